// ===== rtl/cidf_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN ID filter package
// Shared widths, opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package cidf_pkg;

  // Field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned ID_W     = 29;
  localparam int unsigned STATUS_W = 2;

  // Default depth of each ID list
  localparam int unsigned LIST_DEPTH = 16;

  // Request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_CHECK       = 3'd0,
    OP_ADD_ALLOW   = 3'd1,
    OP_ADD_BLOCK   = 3'd2,
    OP_CLEAR_ALLOW = 3'd3,
    OP_CLEAR_BLOCK = 3'd4
  } opcode_e;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_PRESENT = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/cidf_if.sv =====
// ----------------------------------------------------------------------------
// CAN ID filter channels
// Request channel (opcode, CAN ID) and response channel (allowed, status).
// ----------------------------------------------------------------------------
`default_nettype none

interface cidf_req_if import cidf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] opcode;
  logic [ID_W-1:0] can_id;

  modport source (output valid, output opcode, output can_id, input ready);
  modport sink   (input valid, input opcode, input can_id, output ready);
endinterface

interface cidf_rsp_if import cidf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                allowed;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output allowed, output status, input ready);
  modport sink   (input valid, input allowed, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/cidf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module cidf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/can_id_list_filter_top.sv =====
// Operation: a check or add scans its list one entry per cycle from the shared
//   RAM's single read port, early exit on a hit; a clear or unused opcode skips
//   the scan. The response is registered and shows the cycle after the item
//   finishes, which waits while a previous response is still held.
// Flow: one request at a time; a new one is taken only in idle.
// Reset: both list counts and allow_all clear to zero; list RAM is not cleared.
// ----------------------------------------------------------------------------
// CAN ID acceptance filter
// Allow list and block list held in one RAM, searched by a linear scan.
// ----------------------------------------------------------------------------
`default_nettype none

module can_id_list_filter_top import cidf_pkg::*; #(
  parameter int unsigned ListDepth = LIST_DEPTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cidf_req_if.sink    req,
  cidf_rsp_if.source  rsp,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_wdata_i
);

  localparam int unsigned CntW  = $clog2(ListDepth + 1);
  localparam int unsigned AddrW = ((2 * ListDepth) > 1) ? $clog2(2 * ListDepth) : 1;

  state_e               state_q, state_d;
  opcode_e              op_q;
  logic [ID_W-1:0]      id_q;
  logic                 sel_q;      // 0 allow list, 1 block list
  logic [CntW-1:0]      idx_q;
  logic                 pend_q;     // read data valid for compare
  logic [CntW-1:0]      allow_cnt_q, block_cnt_q;
  logic                 allow_all_q;
  logic                 out_valid_q;
  logic                 allowed_q;
  status_e              status_q;

  logic                 accept;
  logic [CntW-1:0]      cnt;
  logic [ID_W-1:0]      rd_data;
  logic                 hit;
  logic                 scan_op;
  logic                 scan_end;
  logic                 out_free;
  logic                 finish;
  logic                 issue;
  logic                 full;
  logic                 do_write;
  logic [AddrW-1:0]     base;
  logic [AddrW-1:0]     rd_addr;
  logic [AddrW-1:0]     wr_addr;
  logic                 allowed_d;
  status_e              status_d;

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_all_q <= 1'b0;
    end else if (cfg_we_i) begin
      allow_all_q <= cfg_wdata_i;
    end
  end

  // Shared scan terms
  assign accept   = req.valid && req.ready;
  assign cnt      = sel_q ? block_cnt_q : allow_cnt_q;
  assign hit      = pend_q && (rd_data == id_q);
  assign scan_op  = (op_q == OP_CHECK) || (op_q == OP_ADD_ALLOW) || (op_q == OP_ADD_BLOCK);
  assign scan_end = hit || (idx_q == cnt);
  assign out_free = !out_valid_q || rsp.ready;
  assign full     = (cnt == CntW'(ListDepth));
  assign base     = sel_q ? AddrW'(ListDepth) : '0;
  assign rd_addr  = base + AddrW'(idx_q);
  assign wr_addr  = base + AddrW'(cnt);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (finish) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req.ready = 1'b0;
    finish    = 1'b0;
    issue     = 1'b0;
    unique case (state_q)
      ST_IDLE: req.ready = 1'b1;
      ST_SCAN: begin
        finish = out_free && (!scan_op || scan_end);
        issue  = scan_op && !scan_end;
      end
      default: ;
    endcase
  end

  // Result of the finished item
  always_comb begin
    allowed_d = 1'b0;
    status_d  = STAT_DONE;
    do_write  = 1'b0;
    unique case (op_q)
      OP_CHECK: allowed_d = allow_all_q ? !hit : hit;
      OP_ADD_ALLOW, OP_ADD_BLOCK: begin
        if (hit) begin
          status_d = STAT_PRESENT;
        end else if (full) begin
          status_d = STAT_FULL;
        end else begin
          do_write = finish;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Scan index and compare pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else if (accept) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else if (issue) begin
      idx_q  <= idx_q + CntW'(1);
      pend_q <= 1'b1;
    end
  end

  // Request capture and list select
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= opcode_e'(req.opcode);
      id_q <= req.can_id;
      unique case (opcode_e'(req.opcode))
        OP_CHECK:     sel_q <= allow_all_q;
        OP_ADD_BLOCK: sel_q <= 1'b1;
        default:      sel_q <= 1'b0;
      endcase
    end
  end

  // List counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_cnt_q <= '0;
      block_cnt_q <= '0;
    end else if (finish) begin
      if (do_write && !sel_q) allow_cnt_q <= allow_cnt_q + CntW'(1);
      if (do_write && sel_q)  block_cnt_q <= block_cnt_q + CntW'(1);
      if (op_q == OP_CLEAR_ALLOW) allow_cnt_q <= '0;
      if (op_q == OP_CLEAR_BLOCK) block_cnt_q <= '0;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      allowed_q <= allowed_d;
      status_q  <= status_d;
    end
  end

  assign rsp.valid   = out_valid_q;
  assign rsp.allowed = allowed_q;
  assign rsp.status  = status_q;

  // Both lists share one RAM: allow list low half, block list high half
  cidf_ram #(
    .Width (ID_W),
    .Depth (2 * ListDepth)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (wr_addr),
    .wdata_i (id_q),
    .re_i    (issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

endmodule

`default_nettype wire

// ===== tb/tb_can_id_list_filter_top.sv =====
// ----------------------------------------------------------------------------
// CAN ID acceptance filter testbench
// Drives opcode/ID beats into the filter, tracks the allow and block lists in
// a local model, and compares each response beat against the predicted one.
// Covers directed edge cases, random list traffic under varying backpressure,
// a long response stall, and allow_all changes between traffic phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_can_id_list_filter_top;
  import cidf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Spare opcodes the filter must treat as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [ID_W-1:0] ID_MAX         = {ID_W{1'b1}};

  // Index into the model's list store
  localparam int ALLOW_SEL = 0;
  localparam int BLOCK_SEL = 1;

  localparam int STALL_LIMIT = 3000;  // cycles with no beat before giving up
  localparam int TAIL_CYCLES = 40;    // settle time after the last response
  localparam int POOL_SIZE   = 24;

  typedef struct packed {
    logic    allowed;
    status_e status;
  } filter_rsp_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  cidf_req_if req_if ();
  cidf_rsp_if rsp_if ();

  can_id_list_filter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_if),
    .rsp         (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Filter model state
  logic [ID_W-1:0] list_ids [2][LIST_DEPTH];
  int unsigned     list_cnt [2] = '{0, 0};
  logic            mdl_allow_all = 1'b0;

  filter_rsp_t     expected_rsp [$];
  int unsigned     err_count   = 0;
  int unsigned     idle_cycles = 0;

  // Traffic shaping knobs
  int unsigned     src_idle_pct = 0;
  int unsigned     snk_idle_pct = 0;
  logic            hold_rsp     = 1'b0;
  logic [ID_W-1:0] id_pool [POOL_SIZE];

  // Clock: 10 ns period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Model lookups and updates
  function automatic bit on_list(int sel, logic [ID_W-1:0] id);
    for (int i = 0; i < list_cnt[sel]; i++) begin
      if (list_ids[sel][i] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic status_e list_insert(int sel, logic [ID_W-1:0] id);
    if (on_list(sel, id)) return STAT_PRESENT;  // duplicate wins over full
    if (list_cnt[sel] >= LIST_DEPTH) return STAT_FULL;
    list_ids[sel][list_cnt[sel]] = id;
    list_cnt[sel]++;
    return STAT_DONE;
  endfunction

  function automatic filter_rsp_t filter_response(logic [OP_W-1:0] op,
                                                  logic [ID_W-1:0] id);
    filter_rsp_t r;
    r.allowed = 1'b0;
    r.status  = STAT_DONE;
    case (op)
      OP_CHECK: begin
        if (mdl_allow_all) r.allowed = !on_list(BLOCK_SEL, id);
        else r.allowed = on_list(ALLOW_SEL, id);
      end
      OP_ADD_ALLOW:   r.status = list_insert(ALLOW_SEL, id);
      OP_ADD_BLOCK:   r.status = list_insert(BLOCK_SEL, id);
      OP_CLEAR_ALLOW: list_cnt[ALLOW_SEL] = 0;
      OP_CLEAR_BLOCK: list_cnt[BLOCK_SEL] = 0;
      default: ;
    endcase
    return r;
  endfunction

  // Response sink readiness
  always @(posedge clk_i) begin
    rsp_if.ready <= !hold_rsp && ($urandom_range(99) >= snk_idle_pct);
  end

  // Predict on each request beat, check each response beat, watch for hangs
  always @(posedge clk_i) begin
    filter_rsp_t exp_rsp;
    if (req_if.valid && req_if.ready) begin
      expected_rsp.insert(expected_rsp.size(),
                          filter_response(req_if.opcode, req_if.can_id));
    end
    if (rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: response beat with nothing expected (allowed %0d status %0d)",
                 $time, rsp_if.allowed, rsp_if.status);
        err_count++;
      end else begin
        exp_rsp = expected_rsp.pop_front();
        if (rsp_if.allowed !== exp_rsp.allowed) begin
          $display("%0t: allowed mismatch, expected %0d actual %0d",
                   $time, exp_rsp.allowed, rsp_if.allowed);
          err_count++;
        end
        if (rsp_if.status !== exp_rsp.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, exp_rsp.status, rsp_if.status);
          err_count++;
        end
      end
    end
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_can_id_list_filter_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request beat and wait until it is taken; valid stays high
  task automatic send_req(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.can_id <= id;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Stop offering and wait for every outstanding response
  task automatic drain_all();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write, only with the filter idle
  task automatic write_allow_all(input logic val);
    drain_all();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mdl_allow_all = val;
  endtask

  task automatic set_idling(input int unsigned src_pct, input int unsigned snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct <= snk_pct;
  endtask

  // Empty lists, ID extremes, duplicates, full list, spare opcodes, stale entries
  task automatic test_directed();
    set_idling(0, 0);
    send_req(OP_CHECK, '0);
    send_req(OP_ADD_ALLOW, '0);
    send_req(OP_ADD_ALLOW, '0);
    send_req(OP_ADD_ALLOW, ID_MAX);
    for (int i = 0; i < LIST_DEPTH - 2; i++) begin
      send_req(OP_ADD_ALLOW, ID_W'(i * 37 + 5));
    end
    send_req(OP_ADD_ALLOW, ID_W'(12345));  // list full, dropped
    send_req(OP_ADD_ALLOW, ID_MAX);        // duplicate on a full list
    send_req(OP_CHECK, ID_MAX);
    send_req(OP_ADD_BLOCK, ID_MAX);
    send_req(OP_SPARE_FIRST, ID_MAX);
    send_req(OP_SPARE_LAST, '0);
    send_req(OP_CLEAR_ALLOW, '0);
    send_req(OP_CHECK, ID_MAX);            // old entry must not match after clear
    write_allow_all(1'b1);
    send_req(OP_CHECK, ID_MAX);
    send_req(OP_CHECK, '0);
    send_req(OP_CLEAR_BLOCK, ID_MAX);
    send_req(OP_CHECK, ID_MAX);
  endtask

  // Random list traffic: mostly checks and adds drawn from a small ID pool
  task automatic test_random_traffic(input int unsigned n_items,
                                     input int unsigned src_pct,
                                     input int unsigned snk_pct,
                                     input logic        allow_all);
    int unsigned     pick;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    write_allow_all(allow_all);
    set_idling(src_pct, snk_pct);
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(999);
      if (pick < 480) op = OP_CHECK;
      else if (pick < 680) op = OP_ADD_ALLOW;
      else if (pick < 880) op = OP_ADD_BLOCK;
      else if (pick < 895) op = OP_CLEAR_ALLOW;
      else if (pick < 910) op = OP_CLEAR_BLOCK;
      else op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      if ($urandom_range(99) < 2) id_pool[$urandom_range(POOL_SIZE - 1)] = ID_W'($urandom);
      if ($urandom_range(99) < 80) id = id_pool[$urandom_range(POOL_SIZE - 1)];
      else id = ID_W'($urandom);
      // now and then the sender waits for the filter to go quiet
      if ($urandom_range(59) == 0) drain_all();
      send_req(op, id);
    end
  endtask

  // Long response stall while requests keep coming, so the input backs up
  task automatic test_rsp_stall();
    set_idling(0, 0);
    fork
      begin
        hold_rsp <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_rsp <= 1'b0;
      end
      begin
        for (int n = 0; n < 20; n++) begin
          send_req($urandom_range(1) ? OP_CHECK : OP_ADD_BLOCK,
                   id_pool[$urandom_range(POOL_SIZE - 1)]);
        end
      end
    join
    drain_all();
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.opcode <= '0;
    req_if.can_id <= '0;
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(380, 18, 75, 1'b1);
    test_random_traffic(380, 75, 18, 1'b0);
    test_random_traffic(190, 0, 0, 1'b1);
    test_random_traffic(190, 0, 0, 1'b0);
    test_rsp_stall();

    drain_all();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_can_id_list_filter_top passed");
    end else begin
      $display("tb_can_id_list_filter_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/cidf_pkg.sv
rtl/cidf_if.sv
rtl/cidf_ram.sv
rtl/can_id_list_filter_top.sv
tb/tb_can_id_list_filter_top.sv
